// File: hw/rtl/pbh_pkg.sv
// ----------------------------------------------------------------------------
// pbh_pkg
// Shared constants and types of the programmable bin histogram.
// ----------------------------------------------------------------------------
package pbh_pkg;

    // Bucket count, overflow bucket included.
    localparam int NUM_BUCKETS = 8;
    localparam int NUM_BOUNDS  = NUM_BUCKETS - 1;
    localparam int MAX_N       = NUM_BUCKETS - 1;
    localparam int IDX_W       = $clog2(NUM_BUCKETS);

    // Fixed field widths.
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 32;
    localparam int BCOUNT_W = 3;
    localparam int BINDEX_W = 3;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 32;

    // Exact sum of all counters, and that sum scaled by 100.
    localparam int SUM_W = COUNT_W + $clog2(NUM_BUCKETS);
    localparam int REM_W = SUM_W + PCT_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_LAST  = CFG_IDX_W'(NUM_BOUNDS);

    // Operation codes.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_INCR,
        S_SUM,
        S_SCALE,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

endpackage

// File: hw/rtl/pbh_item_if.sv
// ----------------------------------------------------------------------------
// pbh_item_if
// Input item channel: record or dump request.
// ----------------------------------------------------------------------------
interface pbh_item_if
    import pbh_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [VALUE_W-1:0] sample_value;

    modport source (output valid, output operation, output sample_value, input ready);
    modport sink   (input valid, input operation, input sample_value, output ready);
endinterface

// File: hw/rtl/pbh_result_if.sv
// ----------------------------------------------------------------------------
// pbh_result_if
// Result channel: one transfer per reported bucket, or a single no-data transfer.
// ----------------------------------------------------------------------------
interface pbh_result_if
    import pbh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [BINDEX_W-1:0] bucket_index;
    logic [COUNT_W-1:0]  bucket_total;
    logic [PCT_W-1:0]    cumulative_percent;
    logic                no_data;
    logic                last_item;

    modport source (output valid, output bucket_index, output bucket_total,
                    output cumulative_percent, output no_data, output last_item,
                    input ready);
    modport sink   (input valid, input bucket_index, input bucket_total,
                    input cumulative_percent, input no_data, input last_item,
                    output ready);
endinterface

// File: hw/rtl/pbh_cfg_if.sv
// ----------------------------------------------------------------------------
// pbh_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pbh_cfg_if
    import pbh_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/programmable_bin_histogram.sv
// Record: one bound compare per cycle, then the counter increment, before the next ready.
// Dump: sum the reported buckets, then per reported bucket accumulate, scale by 100,
//   run 7 restoring divide steps and emit, stalling while the result channel is not ready.
// Throughput is one item at a time; the shared 42-bit compare/subtract unit sets the pace.
// Reset clears bucket counters, bound registers and all control state.
// ----------------------------------------------------------------------------
// programmable_bin_histogram
// Histogram with programmable inclusive upper bounds and an overflow bucket.
// ----------------------------------------------------------------------------
module programmable_bin_histogram
    import pbh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pbh_item_if.sink           item,
    pbh_result_if.source       result,
    pbh_cfg_if.sink            cfg
);

    // ------------------------------------------------------------------
    // Control state and configuration
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [BCOUNT_W-1:0]   bound_count_reg, bound_count_next;
    logic [VALUE_W-1:0]    bound_reg [NUM_BOUNDS];
    logic [VALUE_W-1:0]    bound_next [NUM_BOUNDS];
    logic [COUNT_W-1:0]    count_reg [NUM_BUCKETS];
    logic [COUNT_W-1:0]    count_next [NUM_BUCKETS];
    logic                  nodata_reg, nodata_next;
    logic                  out_valid_reg, out_valid_next;

    // ------------------------------------------------------------------
    // Datapath registers (no reset: always written before use)
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [SUM_W-1:0]      total_reg, total_next;
    logic [SUM_W-1:0]      cum_reg, cum_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [PCT_W-1:0]      quo_reg, quo_next;
    logic [2:0]            step_reg, step_next;
    logic [IDX_W-1:0]      last_idx_reg, last_idx_next;
    logic [BINDEX_W-1:0]   out_index_reg, out_index_next;
    logic [COUNT_W-1:0]    out_total_reg, out_total_next;
    logic [PCT_W-1:0]      out_pct_reg, out_pct_next;
    logic                  out_nodata_reg, out_nodata_next;
    logic                  out_last_reg, out_last_next;

    // Bounds in use, saturated to the number of ordinary buckets.
    logic [IDX_W-1:0]      active_n;

    // Shared compare/subtract unit: ge = (a >= b), diff = a - b.
    logic [REM_W-1:0]      cmp_a;
    logic [REM_W-1:0]      cmp_b;
    logic [REM_W:0]        cmp_diff;
    logic                  cmp_ge;

    logic                  is_last;

    assign active_n = (int'(bound_count_reg) > MAX_N) ? IDX_W'(MAX_N)
                                                      : IDX_W'(bound_count_reg);

    assign cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
    assign cmp_ge   = ~cmp_diff[REM_W];

    assign is_last  = nodata_reg || (idx_reg == last_idx_reg);

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    assign result.valid              = out_valid_reg;
    assign result.bucket_index       = out_index_reg;
    assign result.bucket_total       = out_total_reg;
    assign result.cumulative_percent = out_pct_reg;
    assign result.no_data            = out_nodata_reg;
    assign result.last_item          = out_last_reg;

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        bound_count_next = bound_count_reg;
        bound_next       = bound_reg;
        count_next       = count_reg;
        nodata_next      = nodata_reg;
        value_next       = value_reg;
        total_next       = total_reg;
        cum_next         = cum_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        last_idx_next    = last_idx_reg;
        out_index_next   = out_index_reg;
        out_total_next   = out_total_reg;
        out_pct_next     = out_pct_reg;
        out_nodata_next  = out_nodata_reg;
        out_last_next    = out_last_reg;

        // Drop the held result once the sink takes it.
        out_valid_next = out_valid_reg && !result.ready;

        item.ready = (state_reg == S_IDLE);

        // Route the shared unit: bound compare while searching, else divide step.
        if (state_reg == S_SEARCH)
        begin
            cmp_a = REM_W'(bound_reg[idx_reg]);
            cmp_b = REM_W'(value_reg);
        end
        else
        begin
            cmp_a = rem_reg;
            cmp_b = REM_W'(total_reg) << step_reg;
        end

        if (cfg.valid)
        begin
            if (cfg.index == REG_BOUND_COUNT)
            begin
                bound_count_next = cfg.data[BCOUNT_W-1:0];
            end
            else if (cfg.index >= REG_BOUND_FIRST && cfg.index <= REG_BOUND_LAST)
            begin
                for (int b = 0; b < NUM_BOUNDS; b++)
                begin
                    if (cfg.index == CFG_IDX_W'(b + 1))
                    begin
                        bound_next[b] = cfg.data[VALUE_W-1:0];
                    end
                end
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    idx_next   = '0;
                    value_next = item.sample_value;
                    total_next = '0;
                    if (item.operation == OP_DUMP)
                    begin
                        state_next = S_SUM;
                    end
                    else
                    begin
                        state_next = S_SEARCH;
                    end
                end
            end

            // Advance through bounds until one is at least the value or the overflow bucket is reached.
            S_SEARCH:
            begin
                if (idx_reg == active_n || cmp_ge)
                begin
                    state_next = S_INCR;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Increment with saturation at all ones.
            S_INCR:
            begin
                if (count_reg[idx_reg] != '1)
                begin
                    count_next[idx_reg] = count_reg[idx_reg] + 1'b1;
                end
                state_next = S_IDLE;
            end

            // Sum the reported buckets.
            S_SUM:
            begin
                total_next = total_reg + SUM_W'(count_reg[idx_reg]);
                if (idx_reg == active_n)
                begin
                    idx_next = '0;
                    cum_next = '0;
                    if (total_next == '0)
                    begin
                        nodata_next = 1'b1;
                        quo_next    = '0;
                        state_next  = S_EMIT;
                    end
                    else
                    begin
                        nodata_next = 1'b0;
                        // Hide an empty overflow bucket.
                        last_idx_next = (count_reg[active_n] != '0) ? active_n
                                                                    : active_n - 1'b1;
                        state_next = S_SCALE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_SCALE:
            begin
                cum_next   = cum_reg + SUM_W'(count_reg[idx_reg]);
                state_next = S_MUL;
            end

            // Scale by 100 as 64 + 32 + 4.
            S_MUL:
            begin
                rem_next = (REM_W'(cum_reg) << 6) + (REM_W'(cum_reg) << 5)
                         + (REM_W'(cum_reg) << 2);
                quo_next  = '0;
                step_next = 3'(PCT_W - 1);
                state_next = S_DIV;
            end

            // One restoring divide step per cycle, MSB first.
            S_DIV:
            begin
                if (cmp_ge)
                begin
                    rem_next = cmp_diff[REM_W-1:0];
                end
                quo_next = {quo_reg[PCT_W-2:0], cmp_ge};
                if (step_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end

            // Load the output register when it is free or being taken.
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_nodata_next = nodata_reg;
                    out_last_next   = is_last;
                    if (nodata_reg)
                    begin
                        out_index_next = '0;
                        out_total_next = '0;
                        out_pct_next   = '0;
                    end
                    else
                    begin
                        out_index_next = BINDEX_W'(idx_reg);
                        out_total_next = count_reg[idx_reg];
                        out_pct_next   = quo_reg;
                    end
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCALE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            bound_count_reg <= '0;
            nodata_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int b = 0; b < NUM_BOUNDS; b++)
            begin
                bound_reg[b] <= '0;
            end
            for (int c = 0; c < NUM_BUCKETS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            bound_count_reg <= bound_count_next;
            nodata_reg      <= nodata_next;
            out_valid_reg   <= out_valid_next;
            bound_reg       <= bound_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        total_reg      <= total_next;
        cum_reg        <= cum_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        last_idx_reg   <= last_idx_next;
        out_index_reg  <= out_index_next;
        out_total_reg  <= out_total_next;
        out_pct_reg    <= out_pct_next;
        out_nodata_reg <= out_nodata_next;
        out_last_reg   <= out_last_next;
    end

endmodule
